@@ rtl/assert_macros.svh @@
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/rau_pkg.sv @@
package rau_pkg;

	localparam int unsigned NUM_BITS = 32;

	localparam logic [1:0] OPC_ADD = 2'd0;
	localparam logic [1:0] OPC_SUB = 2'd1;
	localparam logic [1:0] OPC_MUL = 2'd2;
	localparam logic [1:0] OPC_DIV = 2'd3;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_DIVZERO  = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [1:0]          opcode;
		logic                a_negative;
		logic [NUM_BITS-1:0] a_numerator;
		logic [NUM_BITS-1:0] a_denominator;
		logic                b_negative;
		logic [NUM_BITS-1:0] b_numerator;
		logic [NUM_BITS-1:0] b_denominator;
	} in_item_t;

	typedef struct packed {
		logic                result_negative;
		logic [NUM_BITS-1:0] result_numerator;
		logic [NUM_BITS-1:0] result_denominator;
		logic [1:0]          status;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_GTEST, S_GWAIT, S_DIVGO, S_DWAIT, S_NEXT,
		S_MNA, S_MNB, S_MDEN, S_COMB, S_MN, S_MD, S_RED, S_FINAL
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_GCD_INIT, OP_GCD_DIV, OP_GCD_UPD, OP_DIV_START,
		OP_DIV_WRITE, OP_MUL_NA, OP_MUL_NB, OP_MUL_DAS, OP_COMBINE, OP_MUL_N,
		OP_MUL_D, OP_FINAL
	} dp_op_t;

	typedef enum logic [3:0] {
		J_AN, J_AD, J_BN, J_BD, J_Q1, J_Q2, J_NDEN, J_NG, J_DG
	} div_job_t;

	typedef enum logic [1:0] {G_A, G_B, G_D, G_R} gcd_sel_t;

	typedef struct packed {
		dp_op_t   op;
		div_job_t job;
		gcd_sel_t gsel;
	} ctl_cmd_t;

	typedef struct packed {
		logic err;
		logic y_zero;
		logic div_done;
		logic add_sub;
		logic out_full;
	} dp_stat_t;

endpackage

@@ rtl/rau_in_if.sv @@
interface rau_in_if import rau_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/rau_out_if.sv @@
interface rau_out_if import rau_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/rau_div.sv @@
module rau_div import rau_pkg::*; #(
	parameter int unsigned W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2*W:0]     dividend,
	input  logic [2*W-1:0]   divisor,
	output logic             done,
	output logic [2*W:0]     quotient,
	output logic [2*W-1:0]   remainder
);
	localparam int unsigned DW = 2 * W;
	localparam int unsigned NW = 2 * W + 1;
	localparam int unsigned CW = $clog2(NW);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] shifted;
	logic [NW-1:0] diff;
	logic          ge;

	// restoring step: one quotient bit per cycle, dividend shifts out as quotient shifts in
	assign shifted = {rem_q, quo_q[NW-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

@@ rtl/rau_datapath.sv @@
module rau_datapath import rau_pkg::*; #(
	parameter int unsigned W = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctl_cmd_t  cmd,
	input  in_item_t  in_item,
	input  logic      out_ready,
	output dp_stat_t  stat,
	output logic      out_valid,
	output out_item_t out_item
);
	localparam int unsigned DW = 2 * W;
	localparam int unsigned NW = 2 * W + 1;

	logic [1:0]    op_q;
	logic          sa_q, sb_q, err_q, neg_q;
	logic [W-1:0]  an_q, ad_q, bn_q, bd_q, t1_q, t2_q;
	logic [DW-1:0] x_q, y_q, na_q, nb_q, den_q, rem_q;
	logic [NW-1:0] n_q;
	logic          out_valid_q;
	out_item_t     out_q;

	logic [W-1:0]  ma, mb;
	logic [DW-1:0] prod;
	logic          div_start, div_done;
	logic [NW-1:0] dvd, quo;
	logic [DW-1:0] dvs, drem;
	logic          sb_eff;
	logic [NW-1:0] sum;
	logic          ovf;

	rau_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quo),
		.remainder(drem)
	);

	always_comb begin
		ma = an_q;
		mb = bn_q;
		case (cmd.op)
			OP_MUL_NA: begin
				ma = an_q; mb = t1_q;
			end
			OP_MUL_NB: begin
				ma = bn_q; mb = t2_q;
			end
			OP_MUL_DAS: begin
				ma = t2_q; mb = bd_q;
			end
			OP_MUL_N: begin
				ma = an_q; mb = (op_q == OPC_DIV) ? bd_q : bn_q;
			end
			OP_MUL_D: begin
				ma = ad_q; mb = (op_q == OPC_DIV) ? bn_q : bd_q;
			end
			default: begin
				ma = an_q; mb = bn_q;
			end
		endcase
	end
	assign prod = DW'(ma) * DW'(mb);

	always_comb begin
		dvd = NW'(x_q);
		dvs = y_q;
		if (cmd.op == OP_DIV_START) begin
			dvs = x_q;
			case (cmd.job)
				J_AN:   dvd = NW'(an_q);
				J_AD:   dvd = NW'(ad_q);
				J_BN:   dvd = NW'(bn_q);
				J_BD:   dvd = NW'(bd_q);
				J_Q1:   dvd = NW'(bd_q);
				J_Q2:   dvd = NW'(ad_q);
				J_NDEN: begin
					dvd = n_q; dvs = den_q;
				end
				J_NG:   dvd = n_q;
				J_DG:   dvd = NW'(den_q);
				default: dvd = n_q;
			endcase
		end
	end
	assign div_start = (cmd.op == OP_GCD_DIV) || (cmd.op == OP_DIV_START);

	assign sb_eff = sb_q ^ (op_q == OPC_SUB);
	assign sum    = NW'(na_q) + NW'(nb_q);
	assign ovf    = (|n_q[NW-1:W]) || (|den_q[DW-1:W]);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				op_q  <= in_item.opcode;
				sa_q  <= in_item.a_negative;
				sb_q  <= in_item.b_negative;
				an_q  <= in_item.a_numerator[W-1:0];
				ad_q  <= in_item.a_denominator[W-1:0];
				bn_q  <= in_item.b_numerator[W-1:0];
				bd_q  <= in_item.b_denominator[W-1:0];
				err_q <= (in_item.a_denominator[W-1:0] == '0)
					|| (in_item.b_denominator[W-1:0] == '0)
					|| ((in_item.opcode == OPC_DIV) && (in_item.b_numerator[W-1:0] == '0));
			end
			OP_GCD_INIT: begin
				case (cmd.gsel)
					G_A: begin
						x_q <= DW'(an_q); y_q <= DW'(ad_q);
					end
					G_B: begin
						x_q <= DW'(bn_q); y_q <= DW'(bd_q);
					end
					G_D: begin
						x_q <= DW'(ad_q); y_q <= DW'(bd_q);
					end
					default: begin
						x_q <= den_q; y_q <= rem_q;
					end
				endcase
			end
			OP_GCD_UPD: begin
				x_q <= y_q;
				y_q <= drem;
			end
			OP_DIV_WRITE: begin
				case (cmd.job)
					J_AN:   an_q  <= quo[W-1:0];
					J_AD:   ad_q  <= quo[W-1:0];
					J_BN:   bn_q  <= quo[W-1:0];
					J_BD:   bd_q  <= quo[W-1:0];
					J_Q1:   t1_q  <= quo[W-1:0];
					J_Q2:   t2_q  <= quo[W-1:0];
					J_NDEN: rem_q <= drem;
					J_NG:   n_q   <= quo;
					J_DG:   den_q <= quo[DW-1:0];
					default: n_q  <= quo;
				endcase
			end
			OP_MUL_NA:  na_q  <= prod;
			OP_MUL_NB:  nb_q  <= prod;
			OP_MUL_DAS: den_q <= prod;
			OP_COMBINE: begin
				if (sa_q == sb_eff) begin
					n_q <= sum; neg_q <= sa_q;
				end else if (na_q >= nb_q) begin
					n_q <= NW'(na_q - nb_q); neg_q <= sa_q;
				end else begin
					n_q <= NW'(nb_q - na_q); neg_q <= sb_eff;
				end
			end
			OP_MUL_N: begin
				n_q   <= NW'(prod);
				neg_q <= sa_q ^ sb_q;
			end
			OP_MUL_D: den_q <= prod;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_FINAL) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FINAL) begin
			if (err_q || ovf) begin
				out_q.result_negative    <= 1'b0;
				out_q.result_numerator   <= '0;
				out_q.result_denominator <= '0;
				out_q.status             <= err_q ? STAT_DIVZERO : STAT_OVERFLOW;
			end else begin
				out_q.result_negative    <= neg_q && (n_q != '0);
				out_q.result_numerator   <= NUM_BITS'(n_q[W-1:0]);
				out_q.result_denominator <= NUM_BITS'(den_q[W-1:0]);
				out_q.status             <= STAT_OK;
			end
		end
	end

	assign stat.err      = err_q;
	assign stat.y_zero   = (y_q == '0);
	assign stat.div_done = div_done;
	assign stat.add_sub  = (op_q == OPC_ADD) || (op_q == OPC_SUB);
	assign stat.out_full = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
endmodule

@@ rtl/rau_ctrl.sv @@
module rau_ctrl import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  dp_stat_t stat,
	output logic     in_ready,
	output ctl_cmd_t cmd
);
	state_t   state_q, state_d;
	div_job_t job_q, job_d;
	gcd_sel_t gsel_q, gsel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q   <= J_AN;
			gsel_q  <= G_A;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
			gsel_q  <= gsel_d;
		end
	end

	always_comb begin
		state_d = state_q;
		job_d   = job_q;
		gsel_d  = gsel_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_CHECK;
			S_CHECK: begin
				if (stat.err) begin
					state_d = S_FINAL;
				end else begin
					gsel_d  = G_A;
					state_d = S_GTEST;
				end
			end
			S_GTEST: begin
				if (stat.y_zero) begin
					state_d = S_DIVGO;
					case (gsel_q)
						G_A: job_d = J_AN;
						G_B: job_d = J_BN;
						G_D: job_d = J_Q1;
						default: job_d = J_NG;
					endcase
				end else begin
					state_d = S_GWAIT;
				end
			end
			S_GWAIT: if (stat.div_done) state_d = S_GTEST;
			S_DIVGO: state_d = S_DWAIT;
			S_DWAIT: if (stat.div_done) state_d = S_NEXT;
			S_NEXT: begin
				case (job_q)
					J_AN: begin
						job_d = J_AD; state_d = S_DWAIT;
					end
					J_AD: begin
						gsel_d = G_B; state_d = S_GTEST;
					end
					J_BN: begin
						job_d = J_BD; state_d = S_DWAIT;
					end
					J_BD: begin
						if (stat.add_sub) begin
							gsel_d = G_D; state_d = S_GTEST;
						end else begin
							state_d = S_MN;
						end
					end
					J_Q1: begin
						job_d = J_Q2; state_d = S_DWAIT;
					end
					J_Q2: state_d = S_MNA;
					J_NDEN: begin
						gsel_d = G_R; state_d = S_GTEST;
					end
					J_NG: begin
						job_d = J_DG; state_d = S_DWAIT;
					end
					default: state_d = S_FINAL;
				endcase
			end
			S_MNA:  state_d = S_MNB;
			S_MNB:  state_d = S_MDEN;
			S_MDEN: state_d = S_COMB;
			S_COMB: state_d = S_RED;
			S_MN:   state_d = S_MD;
			S_MD:   state_d = S_RED;
			S_RED: begin
				job_d = J_NDEN; state_d = S_DWAIT;
			end
			S_FINAL: if (!stat.out_full) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.job  = job_q;
		cmd.gsel = gsel_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_CHECK: begin
				if (!stat.err) begin
					cmd.op = OP_GCD_INIT; cmd.gsel = G_A;
				end
			end
			S_GTEST: if (!stat.y_zero) cmd.op = OP_GCD_DIV;
			S_GWAIT: if (stat.div_done) cmd.op = OP_GCD_UPD;
			S_DIVGO: cmd.op = OP_DIV_START;
			S_DWAIT: if (stat.div_done) cmd.op = OP_DIV_WRITE;
			S_NEXT: begin
				case (job_q)
					J_AN: begin
						cmd.op = OP_DIV_START; cmd.job = J_AD;
					end
					J_AD: begin
						cmd.op = OP_GCD_INIT; cmd.gsel = G_B;
					end
					J_BN: begin
						cmd.op = OP_DIV_START; cmd.job = J_BD;
					end
					J_BD: begin
						if (stat.add_sub) begin
							cmd.op = OP_GCD_INIT; cmd.gsel = G_D;
						end
					end
					J_Q1: begin
						cmd.op = OP_DIV_START; cmd.job = J_Q2;
					end
					J_NDEN: begin
						cmd.op = OP_GCD_INIT; cmd.gsel = G_R;
					end
					J_NG: begin
						cmd.op = OP_DIV_START; cmd.job = J_DG;
					end
					default: cmd.op = OP_NONE;
				endcase
			end
			S_MNA:  cmd.op = OP_MUL_NA;
			S_MNB:  cmd.op = OP_MUL_NB;
			S_MDEN: cmd.op = OP_MUL_DAS;
			S_COMB: cmd.op = OP_COMBINE;
			S_MN:   cmd.op = OP_MUL_N;
			S_MD:   cmd.op = OP_MUL_D;
			S_RED: begin
				cmd.op = OP_DIV_START; cmd.job = J_NDEN;
			end
			S_FINAL: if (!stat.out_full) cmd.op = OP_FINAL;
			default: cmd.op = OP_NONE;
		endcase
	end
endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: add, subtract, multiply or divide two
// sign-magnitude fractions and return the result in lowest terms.
// request channel: one request carries the opcode and both operands; it is
// taken only while the unit is idle, one request at a time.
// response channel: one response per request with sign, reduced numerator,
// reduced denominator and status (ok, divide by zero, overflow).
// Latency is data dependent. Every division, modulo and GCD step runs on one
// shared restoring divider; a request needs seven to nine divisions plus one per
// Euclid step of the three or four GCDs. Zero denominators or a division by zero
// skip the divider and finish without any division.
// Only the low WIDTH bits of numerators and denominators are used.
// The response sits in an output register; the next request is accepted
// while it waits. When the receiver stalls with a result pending, the
// unit holds the next result until the register frees.
// Reset clears the sequencer and drops any pending response.
`include "assert_macros.svh"

module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int unsigned WIDTH = 32
) (
	input logic       clk,
	input logic       arst_n,
	rau_in_if.sink    request,
	rau_out_if.source response
);
	ctl_cmd_t  cmd;
	dp_stat_t  stat;
	logic      ctl_ready;
	logic      out_valid;
	out_item_t out_item;

	rau_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(request.valid),
		.stat    (stat),
		.in_ready(ctl_ready),
		.cmd     (cmd)
	);

	rau_datapath #(.W(WIDTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (request.data),
		.out_ready(response.ready),
		.stat     (stat),
		.out_valid(out_valid),
		.out_item (out_item)
	);

	assign request.ready  = ctl_ready;
	assign response.valid = out_valid;
	assign response.data  = out_item;

	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, request.valid && request.ready, !request.ready)
	`ASSERT_IMPLIES(a_error_zeroed, clk, arst_n, response.valid && (response.data.status != STAT_OK), (response.data.result_numerator == '0) && (response.data.result_denominator == '0) && !response.data.result_negative)
	`ASSERT_IMPLIES(a_zero_result, clk, arst_n, response.valid && (response.data.status == STAT_OK) && (response.data.result_numerator == '0), !response.data.result_negative && (response.data.result_denominator == NUM_BITS'(1)))
	`ASSERT_IMPLIES(a_load_idle, clk, arst_n, cmd.op == OP_LOAD, ctl_ready && request.valid)
endmodule
